// ===== rtl/core/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, constants and the divider step function of the perspective
// scanline block.
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

  // Visible scanlines; lines at or past this count are inactive.
  localparam int unsigned SCREEN_LINES = 160;
  localparam int unsigned LINE_CMP_W   = 11;

  // Configuration port.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_HORIZON      = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FIRST_ACTIVE = 3'd1;
  localparam logic [CFG_AW-1:0] REG_EYE          = 3'd2;
  localparam logic [CFG_AW-1:0] REG_LATERAL      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ZOOM         = 3'd4;

  localparam logic signed [15:0] ZOOM_RESET = 16'sd256;

  // Stream widths.
  localparam int unsigned IN_W  = 104;
  localparam int unsigned OUT_W = 120;

  // Divider geometry: quotient bits produced per pipeline stage.
  localparam int unsigned DIV_BITS   = 32;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = DIV_BITS / DIV_STEPS;

  typedef struct packed {
    logic        [7:0]  horizon;
    logic        [7:0]  first_active;
    logic signed [15:0] eye;
    logic signed [15:0] lateral;
    logic signed [15:0] zoom;
  } cfg_t;

  typedef struct packed {
    logic        [7:0]  line;
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
  } item_t;

  // Per-line values that ride alongside the depth computation.
  typedef struct packed {
    logic        [7:0]  line;
    logic               active;
    logic signed [17:0] s;
    logic signed [18:0] ns;
    logic signed [17:0] c;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
  } side_t;

  typedef struct packed {
    logic [7:0]          rem;
    logic [DIV_BITS-1:0] work;
    logic [7:0]          md;
    logic                neg;
    logic                zero;
    side_t               side;
  } div_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] depth;
    side_t               side;
  } dep_t;

  typedef struct packed {
    logic        [7:0]  line_out;
    logic               active;
    logic signed [15:0] mat_a;
    logic signed [15:0] mat_b;
    logic signed [15:0] mat_c;
    logic signed [15:0] mat_d;
    logic signed [23:0] ref_x;
    logic signed [23:0] ref_y;
  } res_t;

  // Restoring division steps. The work word starts as the dividend and
  // shifts left one bit per step, collecting quotient bits at the bottom.
  function automatic div_t div_iter(div_t x);
    div_t       y;
    logic [8:0] r9;
    y = x;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r9     = {y.rem, y.work[DIV_BITS-1]};
      y.work = {y.work[DIV_BITS-2:0], 1'b0};
      if (r9 >= {1'b0, y.md}) begin
        y.rem     = 8'(r9 - {1'b0, y.md});
        y.work[0] = 1'b1;
      end else begin
        y.rem = r9[7:0];
      end
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/psa_front.sv =====
// ----------------------------------------------------------------------------
// psa_front
// Input stage: decodes the line, forms the divider operands as sign and
// magnitude, and scales sine and cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire psa_pkg::cfg_t  cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire psa_pkg::item_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output psa_pkg::div_t      out_data
);
  import psa_pkg::*;

  localparam logic [LINE_CMP_W-1:0] LINE_LIM = LINE_CMP_W'(SCREEN_LINES);

  logic        v_r;
  div_t        data_r;
  div_t        data_nxt;
  logic [15:0] diff16;
  logic [15:0] mag16;
  logic [8:0]  d9;
  logic        nn;
  logic        dn;
  logic        act;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = data_r;

  always_comb begin
    // The dividend is (eye - horizon) << 16 wrapped to 32 bits, so only the
    // low 16 bits of the difference survive, in the upper half.
    diff16 = cfg.eye - {8'd0, cfg.horizon};
    nn     = diff16[15];
    mag16  = nn ? 16'(16'd0 - diff16) : diff16;
    d9     = {1'b0, in_data.line} - {1'b0, cfg.horizon};
    dn     = d9[8];
    act    = (in_data.line >= cfg.first_active) &&
             ({{(LINE_CMP_W-8){1'b0}}, in_data.line} < LINE_LIM);

    data_nxt.rem        = 8'd0;
    data_nxt.work       = {mag16, 16'd0};
    data_nxt.md         = dn ? 8'(9'd0 - d9) : d9[7:0];
    data_nxt.neg        = nn ^ dn;
    data_nxt.zero       = (in_data.line == cfg.horizon);
    data_nxt.side.line  = in_data.line;
    data_nxt.side.active = act;
    data_nxt.side.s     = {in_data.sine, 2'b00};
    data_nxt.side.c     = {in_data.cosine, 2'b00};
    data_nxt.side.ns    = 19'sd0 - {in_data.sine[15], in_data.sine, 2'b00};
    data_nxt.side.cam_x = in_data.cam_x;
    data_nxt.side.cam_y = in_data.cam_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

  // The horizon flag and a zero divisor magnitude must agree.
  a_zero_div : assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (data_r.zero == (data_r.md == 8'd0)))
    else $error("horizon flag disagrees with divisor");

endmodule

`default_nettype wire

// ===== rtl/core/psa_div.sv =====
// ----------------------------------------------------------------------------
// psa_div
// Pipelined restoring divider for the per-line depth. Several quotient bits
// per stage, then a stage that restores the sign and zeroes the horizon.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_div (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire psa_pkg::div_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output psa_pkg::dep_t     out_data
);
  import psa_pkg::*;

  localparam int unsigned NSTG = DIV_STAGES + 1;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_in;
  logic [NSTG:0]   rdy;
  div_t            it_r   [DIV_STAGES];
  div_t            it_nxt [DIV_STAGES];
  dep_t            dep_r;
  dep_t            dep_nxt;
  div_t            last;

  always_comb begin
    rdy[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_in      = {v_r[NSTG-2:0], in_valid};
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = dep_r;

  always_comb begin
    it_nxt[0] = div_iter(in_data);
    for (int k = 1; k < DIV_STAGES; k++) begin
      it_nxt[k] = div_iter(it_r[k-1]);
    end
  end

  always_comb begin
    last         = it_r[DIV_STAGES-1];
    dep_nxt.side = last.side;
    if (last.zero || !last.side.active) begin
      dep_nxt.depth = '0;
    end else if (last.neg) begin
      dep_nxt.depth = DIV_BITS'(0) - last.work;
    end else begin
      dep_nxt.depth = last.work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[k]) begin
        it_r[k] <= it_nxt[k];
      end
    end
    if (rdy[NSTG-1]) begin
      dep_r <= dep_nxt;
    end
  end

  // A partial remainder always stays below a nonzero divisor.
  a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[DIV_STAGES-1] && (it_r[DIV_STAGES-1].md != 8'd0)) |->
      (it_r[DIV_STAGES-1].rem < it_r[DIV_STAGES-1].md))
    else $error("divider remainder out of range");

  a_inactive_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !dep_r.side.active) |-> (dep_r.depth == '0))
    else $error("inactive line carries a nonzero depth");

endmodule

`default_nettype wire

// ===== rtl/core/psa_xform.sv =====
// ----------------------------------------------------------------------------
// psa_xform
// Multiply pipeline: depth times zoom, then the matrix and the row offsets,
// then the rotated offsets, and finally the reference point sums.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_xform (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire psa_pkg::cfg_t cfg,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire psa_pkg::dep_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output psa_pkg::res_t     out_data
);
  import psa_pkg::*;

  localparam int unsigned NSTG = 4;

  typedef struct packed {
    logic signed [31:0] scale;
    side_t              side;
  } x0_t;

  typedef struct packed {
    logic signed [15:0] ui;
    logic signed [15:0] vi;
    logic signed [15:0] pa;
    logic signed [15:0] pb;
    logic signed [15:0] pc;
    side_t              side;
  } x1_t;

  typedef struct packed {
    logic signed [31:0] t_vs;
    logic signed [31:0] t_uc;
    logic signed [31:0] t_un;
    logic signed [31:0] t_vc;
    logic signed [15:0] pa;
    logic signed [15:0] pb;
    logic signed [15:0] pc;
    side_t              side;
  } x2_t;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_in;
  logic [NSTG:0]   rdy;

  x0_t  x0_r, x0_nxt;
  x1_t  x1_r, x1_nxt;
  x2_t  x2_r, x2_nxt;
  res_t res_r, res_nxt;

  logic signed [31:0] zoom32;
  logic signed [31:0] q32;
  logic signed [31:0] si32;
  logic signed [31:0] nlat32;
  logic signed [31:0] le32;
  logic signed [31:0] u_prod;
  logic signed [31:0] v_prod;
  logic signed [31:0] pa_prod;
  logic signed [31:0] pb_prod;
  logic signed [31:0] pc_prod;
  logic signed [16:0] nlat;
  logic signed [16:0] le;
  logic signed [31:0] ui32;
  logic signed [31:0] vi32;
  logic signed [31:0] rx;
  logic signed [31:0] ry;

  always_comb begin
    rdy[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_in      = {v_r[NSTG-2:0], in_valid};
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = res_r;

  // Stage 0: scale = depth * zoom, wrapped to 32 bits.
  always_comb begin
    zoom32       = {{16{cfg.zoom[15]}}, cfg.zoom};
    x0_nxt.scale = $signed(in_data.depth) * zoom32;
    x0_nxt.side  = in_data.side;
  end

  // Stage 1: matrix terms from scale >> 16 and row offsets from scale >> 8.
  always_comb begin
    q32     = {{8{x0_r.scale[31]}}, x0_r.scale[31:8]};
    si32    = {{16{x0_r.scale[31]}}, x0_r.scale[31:16]};
    nlat    = 17'sd0 - {cfg.lateral[15], cfg.lateral};
    le      = {9'd0, x0_r.side.line} - {cfg.eye[15], cfg.eye};
    nlat32  = {{15{nlat[16]}}, nlat};
    le32    = {{15{le[16]}}, le};
    u_prod  = nlat32 * q32;
    v_prod  = le32 * q32;
    pa_prod = si32 * {{14{x0_r.side.c[17]}}, x0_r.side.c};
    pb_prod = si32 * {{14{x0_r.side.s[17]}}, x0_r.side.s};
    pc_prod = si32 * {{13{x0_r.side.ns[18]}}, x0_r.side.ns};

    x1_nxt.ui   = u_prod[31:16];
    // v carries an extra factor of two before the shift.
    x1_nxt.vi   = v_prod[30:15];
    x1_nxt.pa   = pa_prod[31:16];
    x1_nxt.pb   = pb_prod[31:16];
    x1_nxt.pc   = pc_prod[31:16];
    x1_nxt.side = x0_r.side;
  end

  // Stage 2: rotate the offsets.
  always_comb begin
    ui32 = {{16{x1_r.ui[15]}}, x1_r.ui};
    vi32 = {{16{x1_r.vi[15]}}, x1_r.vi};
    x2_nxt.t_vs = vi32 * {{14{x1_r.side.s[17]}}, x1_r.side.s};
    x2_nxt.t_uc = ui32 * {{14{x1_r.side.c[17]}}, x1_r.side.c};
    x2_nxt.t_un = ui32 * {{13{x1_r.side.ns[18]}}, x1_r.side.ns};
    x2_nxt.t_vc = vi32 * {{14{x1_r.side.c[17]}}, x1_r.side.c};
    x2_nxt.pa   = x1_r.pa;
    x2_nxt.pb   = x1_r.pb;
    x2_nxt.pc   = x1_r.pc;
    x2_nxt.side = x1_r.side;
  end

  // Stage 3: add the camera position and drop eight fraction bits.
  always_comb begin
    rx = x2_r.t_vs + x2_r.t_uc + x2_r.side.cam_x;
    ry = x2_r.t_un + x2_r.t_vc + x2_r.side.cam_y;
    res_nxt.line_out = x2_r.side.line;
    res_nxt.active   = x2_r.side.active;
    if (x2_r.side.active) begin
      res_nxt.mat_a = x2_r.pa;
      res_nxt.mat_b = x2_r.pb;
      res_nxt.mat_c = x2_r.pc;
      res_nxt.mat_d = x2_r.pa;
      res_nxt.ref_x = rx[31:8];
      res_nxt.ref_y = ry[31:8];
    end else begin
      res_nxt.mat_a = '0;
      res_nxt.mat_b = '0;
      res_nxt.mat_c = '0;
      res_nxt.mat_d = '0;
      res_nxt.ref_x = '0;
      res_nxt.ref_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x0_r <= x0_nxt;
    end
    if (rdy[1]) begin
      x1_r <= x1_nxt;
    end
    if (rdy[2]) begin
      x2_r <= x2_nxt;
    end
    if (rdy[3]) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/perspective_scanline_affine.sv =====
// ----------------------------------------------------------------------------
// perspective_scanline_affine
// Per-scanline floor projection: rotation/scale matrix and reference point.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat on in_* carries one scanline number, the sine and cosine
//   of the view bearing (Q14) and the camera position. Each output beat on
//   out_* returns that line's matrix (pa, pb, pc, pd) and reference point,
//   with out_tuser set when the line is active. Results leave in input order.
//   An accepted beat passes one operand stage, eight divider stages of four
//   quotient bits each, a sign stage and four multiply/add stages. One beat
//   is taken every cycle unless stalled. Users must write the configuration
//   registers on cfg_* while no line is in flight; the block does not
//   enforce this. Reset clears all stage valid bits and loads the register
//   defaults (zoom 256, all others 0). When the receiver holds out_tready
//   low, the beat in the output register holds, earlier empty stages still
//   fill, and in_tready falls only once every stage holds a line.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_scanline_affine (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // line, sine_value, cosine_value, camera_x, camera_y
  input  wire logic [psa_pkg::IN_W-1:0]     in_tdata,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // line_out, mat_a, mat_b, mat_c, mat_d, ref_x, ref_y
  output logic [psa_pkg::OUT_W-1:0]         out_tdata,
  // active
  output logic                              out_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  input  wire logic                         cfg_we,
  input  wire logic [psa_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [psa_pkg::CFG_DW-1:0]   cfg_wdata
);
  import psa_pkg::*;

  cfg_t  cfg_r;
  item_t item;
  logic  f_valid;
  logic  f_ready;
  div_t  f_data;
  logic  d_valid;
  logic  d_ready;
  dep_t  d_data;
  res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.horizon      <= '0;
      cfg_r.first_active <= '0;
      cfg_r.eye          <= '0;
      cfg_r.lateral      <= '0;
      cfg_r.zoom         <= ZOOM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HORIZON:      cfg_r.horizon      <= cfg_wdata[7:0];
        REG_FIRST_ACTIVE: cfg_r.first_active <= cfg_wdata[7:0];
        REG_EYE:          cfg_r.eye          <= cfg_wdata;
        REG_LATERAL:      cfg_r.lateral      <= cfg_wdata;
        REG_ZOOM:         cfg_r.zoom         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign item.line   = in_tdata[7:0];
  assign item.sine   = in_tdata[23:8];
  assign item.cosine = in_tdata[39:24];
  assign item.cam_x  = in_tdata[71:40];
  assign item.cam_y  = in_tdata[103:72];

  psa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (item),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  psa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  psa_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_data   (d_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {res.ref_y, res.ref_x, res.mat_d, res.mat_c, res.mat_b,
                      res.mat_a, res.line_out};
  assign out_tuser = res.active;

  // An inactive line carries only its line number.
  a_inactive_out : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[OUT_W-1:8] == '0))
    else $error("inactive line has nonzero parameters");

  // The input side only stalls when the whole pipeline is full and blocked.
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while the pipeline had room");

endmodule

`default_nettype wire

// ===== tb/sv/perspective_scanline_affine_tb.sv =====
// ----------------------------------------------------------------------------
// perspective_scanline_affine_tb
// Self-checking bench for the per-scanline floor projection block. Scanline
// beats go in through a bursty sender; every output beat is compared field by
// field with parameters computed here from the same register settings. The
// run steps through directed corner settings and then randomized settings.
// ----------------------------------------------------------------------------
module perspective_scanline_affine_tb;
  import psa_pkg::*;

  localparam int unsigned CLK_HALF     = 4;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PIPE_DEPTH   = 14;
  localparam int unsigned RAND_PHASES  = 12;
  localparam int unsigned PHASE_LINES  = 95;
  localparam int unsigned HOLD_CYCLES  = 90;
  localparam int unsigned FIRST_UNUSED_REG = 5;
  localparam int unsigned LAST_UNUSED_REG  = 7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic [IN_W-1:0]    in_tdata = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [OUT_W-1:0]   out_tdata;
  logic               out_tuser;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr = '0;
  logic [CFG_DW-1:0]  cfg_wdata = '0;

  // Register copies that the projection below works from.
  logic [7:0]  hz_line = 8'd0;
  logic [7:0]  first_line = 8'd0;
  logic [15:0] eye_h = 16'd0;
  logic [15:0] lat_off = 16'd0;
  logic [15:0] zoom_q8 = ZOOM_RESET;

  item_t       line_req_q[$];
  res_t        params_due_q[$];
  item_t       on_bus;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  int unsigned beats_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned ready_mode = 0;

  perspective_scanline_affine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [31:0] sext16(logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
    logic signed [31:0] t;
    t = x;
    return t >>> n;
  endfunction

  // Truncating signed divide; the most negative value over -1 wraps to itself.
  function automatic logic [31:0] div_trunc(logic [31:0] n, logic [31:0] d);
    logic [31:0] mn, md, qq;
    mn = n[31] ? 32'd0 - n : n;
    md = d[31] ? 32'd0 - d : d;
    qq = mn / md;
    return (n[31] ^ d[31]) ? 32'd0 - qq : qq;
  endfunction

  function automatic res_t project_line(item_t it);
    res_t        r;
    logic [31:0] s, c, ns, depth, scale, q, si, u, v, ui, vi, rx, ry, t;
    r = '0;
    r.line_out = it.line;
    if (it.line < first_line || it.line >= SCREEN_LINES) return r;
    s  = sext16(it.sine) << 2;
    c  = sext16(it.cosine) << 2;
    ns = 32'd0 - s;
    if (it.line == hz_line)
      depth = 32'd0;
    else
      depth = div_trunc((sext16(eye_h) - {24'd0, hz_line}) << 16,
                        {24'd0, it.line} - {24'd0, hz_line});
    scale = depth * sext16(zoom_q8);
    q  = asr32(scale, 8);
    si = asr32(scale, 16);
    u  = (32'd0 - sext16(lat_off)) * q;
    v  = ({24'd0, it.line} - sext16(eye_h)) * q * 32'd2;
    ui = asr32(u, 16);
    vi = asr32(v, 16);
    rx = vi * s + ui * c + it.cam_x;
    ry = ui * ns + vi * c + it.cam_y;
    r.active = 1'b1;
    t = asr32(si * c, 16);
    r.mat_a = t[15:0];
    r.mat_d = t[15:0];
    t = asr32(si * s, 16);
    r.mat_b = t[15:0];
    t = asr32(si * ns, 16);
    r.mat_c = t[15:0];
    t = asr32(rx, 8);
    r.ref_x = t[23:0];
    t = asr32(ry, 8);
    r.ref_y = t[23:0];
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
      burst_left = $urandom_range(1, 40);
    end else begin
      if (in_tvalid && in_tready) params_due_q.push_back(project_line(on_bus));
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0 || line_req_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          on_bus = line_req_q.pop_front();
          in_tdata <= {on_bus.cam_y, on_bus.cam_x, on_bus.cosine, on_bus.sine, on_bus.line};
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 10);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Receiver: checks each output beat and stalls in changing patterns, with
  // a long hold-off now and then so the pipeline backs up into in_tready.
  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        beats_seen++;
        got.line_out = out_tdata[7:0];
        got.active   = out_tuser;
        got.mat_a    = out_tdata[23:8];
        got.mat_b    = out_tdata[39:24];
        got.mat_c    = out_tdata[55:40];
        got.mat_d    = out_tdata[71:56];
        got.ref_x    = out_tdata[95:72];
        got.ref_y    = out_tdata[119:96];
        if (params_due_q.size() == 0) begin
          $error("unexpected output beat for line %0d", got.line_out);
          errors++;
        end else begin
          want = params_due_q.pop_front();
          check_field("line_out", want.line_out, got.line_out);
          check_field("active", want.active, got.active);
          check_field("mat_a", want.mat_a, got.mat_a);
          check_field("mat_b", want.mat_b, got.mat_b);
          check_field("mat_c", want.mat_c, got.mat_c);
          check_field("mat_d", want.mat_d, got.mat_d);
          check_field("ref_x", want.ref_x, got.ref_x);
          check_field("ref_y", want.ref_y, got.ref_y);
        end
        if (beats_seen % 300 == 120) hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (ready_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 9) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HORIZON:      hz_line = val[7:0];
      REG_FIRST_ACTIVE: first_line = val[7:0];
      REG_EYE:          eye_h = val;
      REG_LATERAL:      lat_off = val;
      REG_ZOOM:         zoom_q8 = val;
      default: ;
    endcase
  endtask

  // Waits until no line is queued, on the bus or awaiting its output beat.
  task automatic drain();
    do @(negedge clk);
    while (line_req_q.size() != 0 || in_tvalid || params_due_q.size() != 0);
  endtask

  task automatic push_line(logic [7:0] ln, logic [15:0] sn, logic [15:0] cs,
                           logic [31:0] cx, logic [31:0] cy);
    item_t it;
    it.line = ln;
    it.sine = sn;
    it.cosine = cs;
    it.cam_x = cx;
    it.cam_y = cy;
    line_req_q.push_back(it);
  endtask

  function automatic logic [15:0] rand_reg16();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'h0100;
      4:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 1024) - 512);
    endcase
  endfunction

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'sd16384;
          1:       return -16'sd16384;
          2:       return 16'h7FFF;
          default: return 16'h8000;
        endcase
      end
      1:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_cam();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
    endcase
  endfunction

  initial begin
    logic [15:0] hi;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the horizon sits on line 0, so every depth is zero.
    push_line(8'd0, 16'd0, 16'd0, 32'd0, 32'd0);
    push_line(8'd0, 16'sd16384, -16'sd16384, 32'h7FFF_FFFF, 32'h8000_0000);
    push_line(8'd159, -16'sd16384, 16'sd16384, 32'hFFFF_FFFF, 32'd1);
    push_line(8'd160, 16'd100, -16'sd100, 32'd5, 32'd5);
    push_line(8'd255, 16'h7FFF, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF);
    push_line(8'd1, 16'h8000, 16'h7FFF, 32'd12345, -32'sd12345);
    drain();

    write_reg(REG_HORIZON, 16'd80);
    write_reg(REG_FIRST_ACTIVE, 16'd40);
    write_reg(REG_EYE, -16'sd100);
    write_reg(REG_LATERAL, 16'd300);
    write_reg(REG_ZOOM, 16'd256);
    push_line(8'd39, 16'd5000, 16'd9000, 32'd1000, 32'd2000);
    push_line(8'd40, 16'd5000, 16'd9000, 32'd1000, 32'd2000);
    push_line(8'd79, -16'sd16384, 16'd0, 32'hFFFF_0000, 32'd65536);
    push_line(8'd80, 16'd3000, -16'sd3000, 32'h1234_5678, 32'h8765_4321);
    push_line(8'd81, 16'd16384, 16'd16384, 32'd0, 32'd0);
    push_line(8'd120, -16'sd7000, 16'd12000, 32'd777, -32'sd777);
    push_line(8'd159, 16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000);
    push_line(8'd160, 16'd1, 16'd1, 32'd1, 32'd1);
    push_line(8'd200, 16'd1, 16'd1, 32'd1, 32'd1);
    drain();

    // Line 0 against horizon 1 divides the most negative value by -1.
    write_reg(REG_HORIZON, 16'hAB01);
    write_reg(REG_FIRST_ACTIVE, 16'd0);
    write_reg(REG_EYE, -16'sd32767);
    write_reg(REG_LATERAL, 16'h8000);
    write_reg(REG_ZOOM, 16'h7FFF);
    push_line(8'd0, 16'd8000, 16'd14000, 32'd4096, 32'd8192);
    push_line(8'd2, -16'sd16384, 16'd16384, 32'h7FFF_FFFF, 32'h0);
    push_line(8'd159, 16'd11585, 16'd11585, 32'd0, 32'hFFFF_FFFF);
    drain();

    write_reg(REG_HORIZON, 16'd255);
    write_reg(REG_FIRST_ACTIVE, 16'd159);
    write_reg(REG_EYE, 16'h7FFF);
    write_reg(REG_LATERAL, 16'h7FFF);
    write_reg(REG_ZOOM, 16'h8000);
    write_reg(CFG_AW'(FIRST_UNUSED_REG), 16'hFFFF);
    push_line(8'd158, 16'd100, 16'd100, 32'd1, 32'd1);
    push_line(8'd159, 16'd16384, -16'sd16384, 32'h0001_0000, 32'hFFFF_0000);
    push_line(8'd255, 16'd100, 16'd100, 32'd1, 32'd1);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      hi = 16'($urandom_range(0, 255)) << 8;
      case ($urandom_range(0, 3))
        0: write_reg(REG_HORIZON, hi);
        1: write_reg(REG_HORIZON, hi | 16'd255);
        2: write_reg(REG_HORIZON, hi | 16'($urandom_range(0, 159)));
        default: write_reg(REG_HORIZON, hi | 16'($urandom_range(0, 255)));
      endcase
      hi = 16'($urandom_range(0, 255)) << 8;
      case ($urandom_range(0, 4))
        0: write_reg(REG_FIRST_ACTIVE, hi);
        1: write_reg(REG_FIRST_ACTIVE, hi | 16'd159);
        2: write_reg(REG_FIRST_ACTIVE, hi | 16'($urandom_range(0, 255)));
        default: write_reg(REG_FIRST_ACTIVE, hi | 16'($urandom_range(0, 60)));
      endcase
      if ($urandom_range(0, 4) != 0) write_reg(REG_EYE, rand_reg16());
      if ($urandom_range(0, 4) != 0) write_reg(REG_LATERAL, rand_reg16());
      if ($urandom_range(0, 4) != 0) write_reg(REG_ZOOM, rand_reg16());
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_AW'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)),
                  16'($urandom_range(0, 65535)));
      for (int i = 0; i < PHASE_LINES; i++) begin
        push_line($urandom_range(0, 19) < 17 ? 8'($urandom_range(0, 159))
                                             : 8'($urandom_range(0, 255)),
                  rand_trig(), rand_trig(), rand_cam(), rand_cam());
      end
      drain();
    end

    repeat (PIPE_DEPTH + 6) @(posedge clk);
    if (params_due_q.size() != 0) begin
      $error("%0d output beats never arrived", params_due_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
